// ===== rtl/biquad_cascade_filter_macros.svh =====
// assertion macros for the biquad cascade filter
`ifndef BIQUAD_CASCADE_FILTER_MACROS_SVH
`define BIQUAD_CASCADE_FILTER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define BCF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcf assertion failed");
// next-cycle implication, checked out of reset
`define BCF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcf assertion failed");
`else
`define BCF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BCF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/bcf_pkg.sv =====
`default_nettype none

package bcf_pkg;

  typedef enum logic [1:0] {
    FUNC_FILTER = 2'd0,
    FUNC_COEF   = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  localparam int COEF_PER_SEC = 5;
  localparam int COEF_W       = 32;
  localparam int SAMPLE_W     = 16;
  localparam int PROD_W       = 48;
  localparam int DLY_W        = 48;
  localparam int ACC_W        = 50;
  localparam int FRAC_SHIFT   = 28;

  localparam logic signed [COEF_W-1:0] COEF_ONE   = 32'sh1000_0000;
  localparam logic signed [ACC_W-1:0]  ROUND_HALF = 50'sh000_0000_0800_0000;

  // configuration register map
  localparam int          APB_AW     = 3;
  localparam logic [0:0]  REG_ACTIVE = 1'b0;
  localparam logic [3:0]  ACTIVE_RST = 4'd1;

  typedef struct packed {
    logic [1:0]                 func;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [2:0]                 coef_section;
    logic [2:0]                 coef_slot;
    logic signed [COEF_W-1:0]   coef_value;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;
  } out_res_t;

  typedef struct packed {
    logic                     en;
    logic [2:0]               section;
    logic [2:0]               slot;
    logic signed [COEF_W-1:0] value;
  } coef_wr_t;

endpackage

`default_nettype wire

// ===== rtl/bcf_coef_mem.sv =====
`default_nettype none

module bcf_coef_mem
  import bcf_pkg::*;
#(
  parameter int MAX_SECTIONS = 8,
  parameter int SEC_W        = 3
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire coef_wr_t                 wr_i,
  input  wire logic [SEC_W-1:0]         rd_section_i,
  input  wire logic [2:0]               rd_slot_i,
  output logic signed [COEF_W-1:0]      rd_data_o
);

  localparam int DEPTH = MAX_SECTIONS * COEF_PER_SEC;
  localparam int AW    = $clog2(DEPTH);

  logic [COEF_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  vld_q;

  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              wr_hit;

  logic [COEF_W-1:0] rd_q;
  logic              rd_vld_q;
  logic              rd_b0_q;

  // section out of range or slot above a2 is dropped
  assign wr_hit  = wr_i.en && ({2'b00, wr_i.section} < 5'(MAX_SECTIONS)) &&
                   (wr_i.slot <= SLOT_A2);
  assign wr_addr = AW'(AW'(wr_i.section) * AW'(COEF_PER_SEC) + AW'(wr_i.slot));
  assign rd_addr = AW'(AW'(rd_section_i) * AW'(COEF_PER_SEC) + AW'(rd_slot_i));

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      mem_q[wr_addr] <= wr_i.value;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_b0_q  <= 1'b0;
    end else begin
      if (wr_hit) begin
        vld_q[wr_addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr];
      rd_b0_q  <= (rd_slot_i == SLOT_B0);
    end
  end

  // unwritten entries read as a pass-through section
  assign rd_data_o = rd_vld_q ? $signed(rd_q) : (rd_b0_q ? COEF_ONE : '0);

endmodule

`default_nettype wire

// ===== rtl/biquad_cascade_filter.sv =====
`default_nettype none

// Cascade of up to MAX_SECTIONS second-order IIR sections in transposed direct
// form II, Q1.15 samples and Q3.28 coefficients. func 0 filters a sample and
// returns one result; func 1 writes one coefficient word (b0, b1, b2, a1, a2 of
// one section) and func 2 zeroes all delay words, both with no result; func 3
// is dropped. A sample runs through an accept step, eight sequencer steps for
// each of N sections around the one shared 32x16 multiplier and its 50-bit
// accumulator, N being active_sections clamped to MAX_SECTIONS, and a done
// step that loads the output register (held while a previous result is still
// stalled). Input stall is high for the whole run. Section results round half
// up and saturate to 16 bits, delay words saturate to 48 bits, and any such
// event sets saturated. Unwritten coefficients read as pass-through (b0 one,
// others zero). active_sections sits at byte address 0 of the register port,
// reset 1.

`include "biquad_cascade_filter_macros.svh"

module biquad_cascade_filter
  import bcf_pkg::*;
#(
  parameter int MAX_SECTIONS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // sample / command requests
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_req_t           in_req_i,
  // filtered samples
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_res_t               out_res_o,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
  localparam int NDLY  = 2 * MAX_SECTIONS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,   // fetch d0, address b0
    ST_MB0,    // b0*x
    ST_MB1,    // acc = b0*x + d0, b1*x
    ST_ROUND,  // y from acc, acc = b1*x + d1
    ST_MA1,    // a1*y
    ST_MB2,    // acc -= a1*y, b2*x
    ST_D0,     // store d0, acc = b2*x, a2*y
    ST_D1,     // store d1 = acc - a2*y
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  // register port
  logic [3:0] active_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ACTIVE);
  assign prdata = (paddr[2] == REG_ACTIVE) ? 32'(active_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RST;
    end else if (cfg_we) begin
      active_q <= pwdata[3:0];
    end
  end

  // request decode
  logic       in_acc;
  logic       do_filter;
  logic       do_clear;
  coef_wr_t   coef_wr;
  logic [CNT_W-1:0] cnt_new;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign do_filter  = in_acc && (in_req_i.func == FUNC_FILTER);
  assign do_clear   = in_acc && (in_req_i.func == FUNC_CLEAR);

  assign coef_wr.en      = in_acc && (in_req_i.func == FUNC_COEF);
  assign coef_wr.section = in_req_i.coef_section;
  assign coef_wr.slot    = in_req_i.coef_slot;
  assign coef_wr.value   = in_req_i.coef_value;

  // more sections than built are clamped
  assign cnt_new = ({1'b0, active_q} > 5'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS)
                                                         : CNT_W'(active_q);

  // sequencer registers
  logic [SEC_W-1:0]           sec_q;
  logic [CNT_W-1:0]           count_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [SAMPLE_W-1:0] y_q;
  logic                       flag_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic                       out_valid_q;
  out_res_t                   out_res_q;

  // coefficient store
  logic [2:0]               rd_slot;
  logic signed [COEF_W-1:0] coef;

  always_comb begin
    case (state_q)
      ST_LOAD:  rd_slot = SLOT_B0;
      ST_MB0:   rd_slot = SLOT_B1;
      ST_MB1:   rd_slot = SLOT_A1;
      ST_ROUND: rd_slot = SLOT_A1;
      ST_MA1:   rd_slot = SLOT_B2;
      ST_MB2:   rd_slot = SLOT_A2;
      default:  rd_slot = SLOT_B0;
    endcase
  end

  bcf_coef_mem #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .SEC_W        (SEC_W)
  ) u_coef_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (coef_wr),
    .rd_section_i (sec_q),
    .rd_slot_i    (rd_slot),
    .rd_data_o    (coef)
  );

  // delay words, one read port chosen by the step
  logic signed [DLY_W-1:0] dly_q [NDLY];
  logic signed [DLY_W-1:0] dly_rd;

  assign dly_rd = dly_q[{sec_q, (state_q == ST_ROUND)}];

  // shared multiplier: x for the b terms, y for the a terms
  logic                       op_y;
  logic signed [SAMPLE_W-1:0] mul_op;
  logic signed [PROD_W-1:0]   mul;

  assign op_y   = (state_q == ST_MA1) || (state_q == ST_D0);
  assign mul_op = op_y ? y_q : x_q;
  assign mul    = PROD_W'(coef * mul_op);

  // section result: round half up, floor shift, saturate to 16 bits
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [ACC_W-1:0]    y_full;
  logic                       y_hi;
  logic                       y_lo;
  logic signed [SAMPLE_W-1:0] y_sat;

  assign acc_rnd = acc_q + ROUND_HALF;
  assign y_full  = acc_rnd >>> FRAC_SHIFT;
  assign y_hi    = (y_full > ACC_W'(32767));
  assign y_lo    = (y_full < -ACC_W'(32768));
  assign y_sat   = y_hi ? 16'sh7fff : (y_lo ? 16'sh8000 : y_full[SAMPLE_W-1:0]);

  // delay word saturation to 48 bits
  logic signed [ACC_W-1:0] d1_full;
  logic                    d0_hi, d0_lo, d1_hi, d1_lo;
  logic signed [DLY_W-1:0] d0_sat, d1_sat;

  assign d1_full = acc_q - ACC_W'(prod_q);
  assign d0_hi   = !acc_q[ACC_W-1] && (acc_q[ACC_W-2:DLY_W-1] != 2'b00);
  assign d0_lo   = acc_q[ACC_W-1] && (acc_q[ACC_W-2:DLY_W-1] != 2'b11);
  assign d1_hi   = !d1_full[ACC_W-1] && (d1_full[ACC_W-2:DLY_W-1] != 2'b00);
  assign d1_lo   = d1_full[ACC_W-1] && (d1_full[ACC_W-2:DLY_W-1] != 2'b11);
  assign d0_sat  = d0_hi ? {1'b0, {(DLY_W-1){1'b1}}} :
                   (d0_lo ? {1'b1, {(DLY_W-1){1'b0}}} : acc_q[DLY_W-1:0]);
  assign d1_sat  = d1_hi ? {1'b0, {(DLY_W-1){1'b1}}} :
                   (d1_lo ? {1'b1, {(DLY_W-1){1'b0}}} : d1_full[DLY_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NDLY; i++) begin
        dly_q[i] <= '0;
      end
    end else if (do_clear) begin
      for (int i = 0; i < NDLY; i++) begin
        dly_q[i] <= '0;
      end
    end else if (state_q == ST_D0) begin
      dly_q[{sec_q, 1'b0}] <= d0_sat;
    end else if (state_q == ST_D1) begin
      dly_q[{sec_q, 1'b1}] <= d1_sat;
    end
  end

  // sequencing
  logic last_sec;
  logic out_free;

  assign last_sec = ((CNT_W'(sec_q) + CNT_W'(1)) == count_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (do_filter) begin
          state_d = (cnt_new == '0) ? ST_DONE : ST_LOAD;
        end
      end
      ST_LOAD:  state_d = ST_MB0;
      ST_MB0:   state_d = ST_MB1;
      ST_MB1:   state_d = ST_ROUND;
      ST_ROUND: state_d = ST_MA1;
      ST_MA1:   state_d = ST_MB2;
      ST_MB2:   state_d = ST_D0;
      ST_D0:    state_d = ST_D1;
      ST_D1:    state_d = last_sec ? ST_DONE : ST_LOAD;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sec_q       <= '0;
      count_q     <= '0;
      x_q         <= '0;
      y_q         <= '0;
      flag_q      <= 1'b0;
      acc_q       <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      state_q <= state_d;
      // a taken result clears unless the done step reloads it in the same cycle
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (do_filter) begin
            x_q     <= in_req_i.sample_in;
            flag_q  <= 1'b0;
            sec_q   <= '0;
            count_q <= cnt_new;
          end
        end
        ST_LOAD: begin
          acc_q <= ACC_W'(dly_rd);
        end
        ST_MB0: begin
          prod_q <= mul;
        end
        ST_MB1: begin
          acc_q  <= acc_q + ACC_W'(prod_q);
          prod_q <= mul;
        end
        ST_ROUND: begin
          y_q    <= y_sat;
          flag_q <= flag_q | y_hi | y_lo;
          acc_q  <= ACC_W'(dly_rd) + ACC_W'(prod_q);
        end
        ST_MA1: begin
          prod_q <= mul;
        end
        ST_MB2: begin
          acc_q  <= acc_q - ACC_W'(prod_q);
          prod_q <= mul;
        end
        ST_D0: begin
          flag_q <= flag_q | d0_hi | d0_lo;
          acc_q  <= ACC_W'(prod_q);
          prod_q <= mul;
        end
        ST_D1: begin
          flag_q <= flag_q | d1_hi | d1_lo;
          x_q    <= y_q;
          sec_q  <= last_sec ? '0 : SEC_W'(sec_q + SEC_W'(1));
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q          <= 1'b1;
            out_res_q.sample_out <= x_q;
            out_res_q.saturated  <= flag_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // a result only appears out of the done step
  `BCF_ASSERT_IMP(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_DONE))
  // the section counter stays below the clamped count while running
  `BCF_ASSERT_IMP(a_sec_range, clk_i, rst_ni, (state_q != ST_IDLE) && (state_q != ST_DONE), (CNT_W'(sec_q) < count_q))
  // coefficient, clear and dropped requests leave the block idle
  `BCF_ASSERT_NXT(a_cmd_idle, clk_i, rst_ni, in_acc && (in_req_i.func != FUNC_FILTER), state_q == ST_IDLE)
  // done holds while the previous result is still stalled
  `BCF_ASSERT_NXT(a_done_hold, clk_i, rst_ni, (state_q == ST_DONE) && out_valid_q && out_stall_i, state_q == ST_DONE)

endmodule

`default_nettype wire

// ===== sim/biquad_cascade_filter_tb.sv =====
module biquad_cascade_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcf_pkg::*;

  // block size and run shape
  localparam int          SECTIONS    = 8;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned LONG_HOLD   = 300;
  // long enough to cover a sample still running through all eight sections
  localparam int unsigned SETTLE      = 80;

  // saturation bounds of the arithmetic
  localparam longint HALF_LSB = longint'(1) <<< (FRAC_SHIFT - 1);
  localparam longint DLY_MAX  = (longint'(1) <<< (DLY_W - 1)) - 1;
  localparam longint DLY_MIN  = -(longint'(1) <<< (DLY_W - 1));
  localparam longint Y_MAX    = 32767;
  localparam longint Y_MIN    = -32768;

  // stimulus corner values
  localparam logic [15:0] SMP_MAX  = 16'h7fff;
  localparam logic [15:0] SMP_MIN  = 16'h8000;
  localparam logic [15:0] SMP_NEG1 = 16'hffff;
  localparam logic [31:0] COEF_MAX = 32'h7fff_ffff;
  localparam logic [31:0] COEF_MIN = 32'h8000_0000;
  localparam int          A_TAME   = 120_795_955;  // about 0.45 in Q3.28

  // slot codes past the last real coefficient
  localparam logic [2:0] SLOT_OUT = 3'd5;
  localparam logic [2:0] SLOT_TOP = 3'd7;

  typedef struct packed {
    in_req_t  req;
    logic     typed;
    out_res_t want;
  } stim_row_t;

  // block ports, all known from time zero
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_req_t           in_req_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_res_t          out_res_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  // mirror of the block state
  logic signed [COEF_W-1:0] coef_mirror  [SECTIONS][COEF_PER_SEC];
  logic signed [DLY_W-1:0]  delay_mirror [SECTIONS][2];
  logic [3:0]               active_mirror;

  out_res_t    expected_samples [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  bit          calm          = 1'b0;  // no idling on either side
  bit          long_hold_req = 1'b0;

  biquad_cascade_filter #(
    .MAX_SECTIONS(SECTIONS)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_req_i,
    .out_valid_o,
    .out_stall_i,
    .out_res_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t ns: %s", $realtime, what);
    mismatches++;
  endtask

  // clamp to a range, noting when it bites
  function automatic longint clamp_to(input longint v, input longint lo, input longint hi,
                                      inout bit hit);
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // works out what one request does to the mirror and what it returns
  function automatic void predict_request(input in_req_t r, output bit gives,
                                          output out_res_t res);
    longint x, acc, y, d0, d1;
    int     n;
    bit     hit;
    gives = 1'b0;
    res   = '0;
    case (func_e'(r.func))
      FUNC_FILTER: begin
        x   = r.sample_in;
        hit = 1'b0;
        n   = (active_mirror > SECTIONS) ? SECTIONS : int'(active_mirror);
        for (int s = 0; s < n; s++) begin
          acc = longint'(coef_mirror[s][SLOT_B0]) * x + delay_mirror[s][0];
          y   = clamp_to((acc + HALF_LSB) >>> FRAC_SHIFT, Y_MIN, Y_MAX, hit);
          d0  = longint'(coef_mirror[s][SLOT_B1]) * x
                - longint'(coef_mirror[s][SLOT_A1]) * y + delay_mirror[s][1];
          d1  = longint'(coef_mirror[s][SLOT_B2]) * x
                - longint'(coef_mirror[s][SLOT_A2]) * y;
          delay_mirror[s][0] = clamp_to(d0, DLY_MIN, DLY_MAX, hit);
          delay_mirror[s][1] = clamp_to(d1, DLY_MIN, DLY_MAX, hit);
          x = y;
        end
        gives          = 1'b1;
        res.sample_out = x[SAMPLE_W-1:0];
        res.saturated  = hit;
      end
      FUNC_COEF: begin
        if (r.coef_section < SECTIONS && r.coef_slot < COEF_PER_SEC) begin
          coef_mirror[r.coef_section][r.coef_slot] = r.coef_value;
        end
      end
      FUNC_CLEAR: begin
        foreach (delay_mirror[s, k]) delay_mirror[s][k] = '0;
      end
      default: begin
        // unknown function: nothing happens
      end
    endcase
  endfunction

  function automatic in_req_t make_req(input func_e f, input logic [15:0] smp,
                                       input logic [2:0] sec, input logic [2:0] slot,
                                       input logic [31:0] val);
    in_req_t r;
    r.func         = f;
    r.sample_in    = smp;
    r.coef_section = sec;
    r.coef_slot    = slot;
    r.coef_value   = val;
    return r;
  endfunction

  function automatic void sample_row(input logic [15:0] smp, input logic typed,
                                     input logic [15:0] want, input logic sat);
    stim_row_t row;
    row.req              = make_req(FUNC_FILTER, smp, 3'd5, SLOT_TOP, 32'ha5a5_5a5a);
    row.typed            = typed;
    row.want.sample_out  = want;
    row.want.saturated   = sat;
    directed_rows.push_back(row);
  endfunction

  function automatic void cmd_row(input func_e f, input logic [2:0] sec,
                                  input logic [2:0] slot, input logic [31:0] val);
    stim_row_t row;
    row.req   = make_req(f, 16'h5aa5, sec, slot, val);
    row.typed = 1'b0;
    row.want  = '0;
    directed_rows.push_back(row);
  endfunction

  // coefficient word: mostly stable values, some corners, some raw noise
  function automatic logic [31:0] pick_coef(input logic [2:0] slot, input bit tame_only);
    int unsigned p;
    int          span;
    p    = tame_only ? 99 : $urandom_range(0, 99);
    span = (slot == SLOT_A1 || slot == SLOT_A2) ? A_TAME : int'(COEF_ONE);
    if (p < 12) begin
      case ($urandom_range(0, 4))
        0:       return COEF_MAX;
        1:       return COEF_MIN;
        2:       return '0;
        3:       return COEF_ONE;
        default: return 32'(-COEF_ONE);
      endcase
    end
    if (p < 30) return $urandom;
    return 32'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic in_req_t rand_request();
    logic [63:0] raw;
    in_req_t     r;
    int unsigned p;
    raw = {$urandom, $urandom};
    r   = raw[$bits(in_req_t)-1:0];
    p   = $urandom_range(0, 99);
    if (p < 70) begin
      r.func = FUNC_FILTER;
      if ($urandom_range(0, 6) == 0) begin
        case ($urandom_range(0, 4))
          0:       r.sample_in = SMP_MAX;
          1:       r.sample_in = SMP_MIN;
          2:       r.sample_in = '0;
          3:       r.sample_in = SMP_NEG1;
          default: r.sample_in = 16'sd1;
        endcase
      end
    end else if (p < 88) begin
      r.func = FUNC_COEF;
      if ($urandom_range(0, 9) != 0) r.coef_slot = $urandom_range(SLOT_B0, SLOT_A2);
      r.coef_value = pick_coef(r.coef_slot, 1'b0);
    end else if (p < 94) begin
      r.func = FUNC_CLEAR;
    end else begin
      r.func = FUNC_NONE;
    end
    return r;
  endfunction

  // offer one request and hold it until taken; the expectation is queued at that edge
  task automatic issue(input in_req_t r, input logic typed, input out_res_t want);
    bit       gives;
    out_res_t pred;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_request(r, gives, pred);
    if (gives) expected_samples.push_back(typed ? want : pred);
  endtask

  // random sender gap while bursty and not calm
  task automatic sender_pause(input bit bursty);
    if (!calm && bursty && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // one register transfer: setup cycle, then access until pready
  task automatic reg_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // let every expected sample drain, then give anything still busy time to finish
  task automatic settle();
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // result side: random back-pressure, plus one long hold-off when asked
  initial begin : result_sink
    int unsigned tick;
    bit          bursty;
    tick   = 0;
    bursty = 1'b1;
    forever begin
      @(posedge clk_i);
      tick++;
      if (tick % 128 == 0) bursty = $urandom_range(0, 2) != 0;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && bursty && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // every taken result against the oldest expectation
  always @(posedge clk_i) begin : result_check
    out_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_samples.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %0d", out_res_o.sample_out));
      end else begin
        want = expected_samples.pop_front();
        if (out_res_o.sample_out !== want.sample_out)
          flag_mismatch($sformatf("sample_out %0d, wanted %0d",
                                  out_res_o.sample_out, want.sample_out));
        if (out_res_o.saturated !== want.saturated)
          flag_mismatch($sformatf("saturated %b, wanted %b",
                                  out_res_o.saturated, want.saturated));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase_active [7] = '{0, 15, 8, 3, 1, 0, 2};
    int unsigned phase_items  [7] = '{50, 60, 100, 150, 60, 80, 100};
    logic [31:0] rdata;
    logic [3:0]  act;
    bit          bursty;

    // mirror starts as pass-through with empty delay lines
    foreach (coef_mirror[s, k]) coef_mirror[s][k] = (k == SLOT_B0) ? COEF_ONE : '0;
    foreach (delay_mirror[s, k]) delay_mirror[s][k] = '0;
    active_mirror = ACTIVE_RST;

    // pass-through after reset, corners go straight through
    sample_row(16'h0000, 1'b1, 16'h0000, 1'b0);
    sample_row(SMP_MAX, 1'b1, SMP_MAX, 1'b0);
    sample_row(SMP_MIN, 1'b1, SMP_MIN, 1'b0);
    sample_row(16'h5555, 1'b1, 16'h5555, 1'b0);
    // unknown function must leave b0 alone
    cmd_row(FUNC_NONE, 3'd0, SLOT_B0, COEF_MIN);
    sample_row(SMP_NEG1, 1'b1, SMP_NEG1, 1'b0);
    // largest gain: output clips, flag set
    cmd_row(FUNC_COEF, 3'd0, SLOT_B0, COEF_MAX);
    sample_row(SMP_MAX, 1'b1, SMP_MAX, 1'b1);
    sample_row(SMP_MIN, 1'b1, SMP_MIN, 1'b1);
    sample_row(16'h0000, 1'b1, 16'h0000, 1'b0);
    // most negative gain inverts and clips
    cmd_row(FUNC_COEF, 3'd0, SLOT_B0, COEF_MIN);
    sample_row(SMP_MIN, 1'b1, SMP_MAX, 1'b1);
    sample_row(SMP_MAX, 1'b1, SMP_MIN, 1'b1);
    // every slot at its corner, delay words driven into saturation
    cmd_row(FUNC_COEF, 3'd0, SLOT_B0, COEF_MAX);
    cmd_row(FUNC_COEF, 3'd0, SLOT_B1, COEF_MAX);
    cmd_row(FUNC_COEF, 3'd0, SLOT_B2, COEF_MAX);
    cmd_row(FUNC_COEF, 3'd0, SLOT_A1, COEF_MIN);
    cmd_row(FUNC_COEF, 3'd0, SLOT_A2, COEF_MIN);
    sample_row(SMP_MAX, 1'b0, '0, 1'b0);
    sample_row(SMP_MAX, 1'b0, '0, 1'b0);
    // slots past a2 are dropped
    cmd_row(FUNC_COEF, 3'd3, SLOT_OUT, 32'h1234_5678);
    cmd_row(FUNC_COEF, 3'd7, SLOT_TOP, COEF_MIN);
    // clear empties the delay line but keeps the coefficients
    cmd_row(FUNC_CLEAR, 3'd0, SLOT_B0, '0);
    sample_row(16'sd1000, 1'b0, '0, 1'b0);
    sample_row(-16'sd1000, 1'b0, '0, 1'b0);

    // hold reset, then release it on an edge
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    bursty = 1'b1;
    foreach (directed_rows[i]) begin
      issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      sender_pause(bursty);
    end
    in_valid_i <= 1'b0;

    // random phases, each under its own section count
    for (int p = 0; p < 7; p++) begin
      settle();
      act = (p == 5) ? 4'($urandom_range(0, 15)) : 4'(phase_active[p]);
      reg_access(1'b1, APB_AW'(4 * REG_ACTIVE), ($urandom & 32'hffff_fff0) | act, rdata);
      active_mirror = act;
      reg_access(1'b0, APB_AW'(4 * REG_ACTIVE), '0, rdata);
      if (rdata !== 32'(active_mirror))
        flag_mismatch($sformatf("active_sections read %0h, wanted %0h", rdata, active_mirror));

      if (p == 0) begin
        // stable random filters in every section, then a clean start
        for (int s = 0; s < SECTIONS; s++) begin
          for (int k = 0; k < COEF_PER_SEC; k++) begin
            issue(make_req(FUNC_COEF, 16'($urandom), 3'(s), 3'(k), pick_coef(3'(k), 1'b1)),
                  1'b0, '0);
            sender_pause(bursty);
          end
        end
        issue(make_req(FUNC_CLEAR, 16'($urandom), 3'($urandom), 3'($urandom), $urandom),
              1'b0, '0);
      end
      // full cascade with the result side held off: the block backs up into its input
      if (p == 2) long_hold_req = 1'b1;
      // last stretch runs without any idling
      if (p == 6) calm = 1'b1;

      for (int n = 0; n < phase_items[p]; n++) begin
        if (n % 32 == 0) bursty = $urandom_range(0, 2) != 0;
        issue(rand_request(), 1'b0, '0);
        sender_pause(bursty);
      end
      in_valid_i <= 1'b0;
    end

    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
